FILE: hw/rtl/sls_pkg.sv
// Shared constants and cell control types for the sequential list store.
package sls_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int OP_W         = 3;
	localparam int POS_W        = 7;
	localparam int IN_W         = 48;
	localparam int OUT_W        = 48;

	// Operation codes carried in the op field; code seven is unused
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_LOCATE = 3'd2,
		OP_ROTATE = 3'd3,
		OP_REVERSE = 3'd4,
		OP_CLEAR  = 3'd5,
		OP_READ   = 3'd6
	} op_t;

	// What every cell does with its entry at a clock edge
	typedef enum logic [2:0] {
		ACT_HOLD,
		ACT_INSERT,
		ACT_DELETE,
		ACT_ROTATE,
		ACT_SWAP
	} cell_act_t;

	// Broadcast control word for the row of cells
	typedef struct packed {
		cell_act_t act;
		logic      parity;
		logic      cmp;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/sequential_list_store_core.sv
// Bounded list of signed 32-bit values built as a row of cells that shift in step.
//
// Each word on the slave side carries one operation (insert before the first larger
// element, delete at a 1-based position, locate the first equal value, rotate right
// by one, reverse, clear, read at a position); exactly one result word follows on the
// master side with ok, found_position, read_value and the count after the operation.
// An operation runs in steps: the accepting edge loads the compare flags in every
// cell, the execute state applies the shift in all cells at once, and the output
// state loads the output register once any earlier result has been taken. Reverse
// with two or more held entries adds a swap state in which the cells trade
// neighbors in odd-even transposition steps over their order tags. A new word is
// accepted once the previous result has been placed in the output register, while
// that result may still wait for m_tready; a result that is still waiting holds the
// next one back. No clearing pass runs after reset; the fill count alone marks
// which cells hold entries.
module sequential_list_store_core #(
	parameter int CAPACITY = sls_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [2:0] op, [34:3] value, [41:35] position, [47:42] zero
	input  logic [sls_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [0] ok, [7:1] found_position, [39:8] read_value, [46:40] count, [47] zero
	output logic [sls_pkg::OUT_W-1:0] m_tdata
);
	import sls_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWAP,
		S_OUT
	} state_t;

	state_t                   state_q;
	op_t                      op_q;
	logic signed [DATA_W-1:0] val_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         phase_q;
	logic                     ok_q;
	logic [POS_W-1:0]         found_q;
	logic signed [DATA_W-1:0] rd_q;
	logic                     m_tvalid_q;
	logic [OUT_W-1:0]         m_tdata_q;

	cell_ctl_t                ctl;
	logic                     accept;
	logic signed [DATA_W-1:0] in_val;
	logic signed [DATA_W-1:0] cell_value;
	logic [PW-1:0]            pos_x;
	logic [PW-1:0]            n_x;
	logic [PW-1:0]            found_x;
	logic                     pos_ok;
	logic                     full;
	logic [IDX_W-1:0]         pos_m1;
	logic [IDX_W-1:0]         last_idx;
	logic [IDX_W-1:0]         pick_idx;
	logic [CNT_W-1:0]         last_cnt;
	logic                     exec_ok;
	logic [POS_W-1:0]         exec_found;
	logic signed [DATA_W-1:0] exec_rd;

	logic signed [DATA_W-1:0] cdata [CAPACITY];
	logic [IDX_W-1:0]         ctag  [CAPACITY];
	logic [CAPACITY-1:0]      gt_bits;
	logic [CAPACITY-1:0]      eq_bits;
	logic [CAPACITY-1:0]      in_range;
	logic [CAPACITY-1:0]      gt_incl;
	logic [CAPACITY-1:0]      eq_incl;
	logic [CAPACITY-1:0]      past_gt;
	logic [CAPACITY-1:0]      eq_first;
	logic [IDX_W-1:0]         first_idx;
	logic signed [DATA_W-1:0] pick_val;

	// Handshake and field decode
	assign s_tready = state_q == S_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign in_val   = s_tdata[34:3];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Position and count checks
	assign pos_x    = PW'(pos_q);
	assign n_x      = PW'(cnt_q);
	assign pos_ok   = (pos_q != '0) && (pos_x <= n_x);
	assign full     = cnt_q == CAP_C;
	assign pos_m1   = IDX_W'(pos_x - PW'(1));
	assign last_cnt = cnt_q - CNT_W'(1);
	assign last_idx = IDX_W'(last_cnt);
	assign pick_idx = (op_q == OP_READ) ? pos_m1 : last_idx;
	assign found_x  = PW'(first_idx) + PW'(1);

	// Compare runs against the incoming value, the shift against the held one
	assign cell_value = (state_q == S_IDLE) ? in_val : val_q;

	// Drive the broadcast control word
	always_comb begin
		ctl.cmp    = accept;
		ctl.parity = phase_q[0];
		ctl.act    = ACT_HOLD;
		case (state_q)
			S_EXEC: begin
				case (op_q)
					OP_INSERT: ctl.act = full ? ACT_HOLD : ACT_INSERT;
					OP_DELETE: ctl.act = pos_ok ? ACT_DELETE : ACT_HOLD;
					OP_ROTATE: ctl.act = (cnt_q > CNT_W'(1)) ? ACT_ROTATE : ACT_HOLD;
					default:   ctl.act = ACT_HOLD;
				endcase
			end
			S_SWAP: begin
				ctl.act = ACT_SWAP;
			end
			default: begin
				ctl.act = ACT_HOLD;
			end
		endcase
	end

	// Mask flags to held entries and form prefix ORs by doubling shifts
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			in_range[i] = CNT_W'(i) < cnt_q;
		end
		gt_incl = gt_bits & in_range;
		eq_incl = eq_bits & in_range;
		for (int d = 1; d < CAPACITY; d = d * 2) begin
			gt_incl = gt_incl | (gt_incl << d);
			eq_incl = eq_incl | (eq_incl << d);
		end
		past_gt  = gt_incl << 1;
		eq_first = eq_bits & in_range & ~(eq_incl << 1);
	end

	// Encode the first match and select the picked entry
	always_comb begin
		first_idx = '0;
		pick_val  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (eq_first[i]) begin
				first_idx = first_idx | IDX_W'(i);
			end
			if (IDX_W'(i) == pick_idx) begin
				pick_val = pick_val | cdata[i];
			end
		end
	end

	// Result fields of the operation being executed
	always_comb begin
		exec_ok    = 1'b0;
		exec_found = '0;
		exec_rd    = '0;
		case (op_q)
			OP_INSERT: begin
				exec_ok = !full;
			end
			OP_DELETE: begin
				exec_ok = pos_ok;
			end
			OP_LOCATE: begin
				if (|eq_first) begin
					exec_ok    = 1'b1;
					exec_found = found_x[POS_W-1:0];
				end
			end
			OP_ROTATE, OP_REVERSE, OP_CLEAR: begin
				exec_ok = 1'b1;
			end
			OP_READ: begin
				if (pos_ok) begin
					exec_ok = 1'b1;
					exec_rd = pick_val;
				end
			end
			default: begin
				exec_ok = 1'b0;
			end
		endcase
	end

	// Row of cells, each wired to its neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [DATA_W-1:0] l_data;
		logic [IDX_W-1:0]         l_tag;
		logic signed [DATA_W-1:0] r_data;
		logic [IDX_W-1:0]         r_tag;

		if (g == 0) begin : g_first
			assign l_data = '0;
			assign l_tag  = '0;
		end else begin : g_mid_l
			assign l_data = cdata[g-1];
			assign l_tag  = ctag[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign r_data = '0;
			assign r_tag  = '0;
		end else begin : g_mid_r
			assign r_data = cdata[g+1];
			assign r_tag  = ctag[g+1];
		end

		sls_cell #(
			.IDX_W(IDX_W),
			.CNT_W(CNT_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (IDX_W'(g)),
			.count     (cnt_q),
			.pos_m1    (pos_m1),
			.value     (cell_value),
			.past_gt   (past_gt[g]),
			.left_data (l_data),
			.left_tag  (l_tag),
			.right_data(r_data),
			.right_tag (r_tag),
			.pick      (pick_val),
			.data      (cdata[g]),
			.tag       (ctag[g]),
			.gt        (gt_bits[g]),
			.eq        (eq_bits[g])
		);
	end

	// Sequencer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			phase_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded now
			if (m_tvalid_q && m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= op_t'(s_tdata[2:0]);
						val_q   <= in_val;
						pos_q   <= s_tdata[41:35];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					ok_q    <= exec_ok;
					found_q <= exec_found;
					rd_q    <= exec_rd;
					if ((op_q == OP_REVERSE) && (cnt_q > CNT_W'(1))) begin
						phase_q <= '0;
						state_q <= S_SWAP;
					end else begin
						state_q <= S_OUT;
					end
					case (op_q)
						OP_INSERT: begin
							if (!full) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end
						OP_DELETE: begin
							if (pos_ok) begin
								cnt_q <= last_cnt;
							end
						end
						OP_CLEAR: begin
							cnt_q <= '0;
						end
						default: begin
							cnt_q <= cnt_q;
						end
					endcase
				end
				S_SWAP: begin
					phase_q <= phase_q + CNT_W'(1);
					if (phase_q == last_cnt) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, n_x[POS_W-1:0], rd_q, found_q, ok_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Fill count never passes the capacity
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CAP_C)
		else $error("fill count above capacity");

	// An insert into a list with room grows it by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_q == OP_INSERT && !full)
		|=> cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1)))
		else $error("insert did not advance fill count");

	// Transposition steps stay inside the held entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWAP) |-> (phase_q < cnt_q))
		else $error("swap phase beyond fill count");

	// A fresh result appears only after the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_OUT))
		else $error("result word raised outside output state");

endmodule

FILE: hw/rtl/sls_cell.sv
// One list cell: holds an entry and its order tag, trades with its neighbors.
module sls_cell #(
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic                              clk,
	input  sls_pkg::cell_ctl_t                ctl,
	input  logic [IDX_W-1:0]                  idx,
	input  logic [CNT_W-1:0]                  count,
	input  logic [IDX_W-1:0]                  pos_m1,
	input  logic signed [sls_pkg::DATA_W-1:0] value,
	input  logic                              past_gt,
	input  logic signed [sls_pkg::DATA_W-1:0] left_data,
	input  logic [IDX_W-1:0]                  left_tag,
	input  logic signed [sls_pkg::DATA_W-1:0] right_data,
	input  logic [IDX_W-1:0]                  right_tag,
	input  logic signed [sls_pkg::DATA_W-1:0] pick,
	output logic signed [sls_pkg::DATA_W-1:0] data,
	output logic [IDX_W-1:0]                  tag,
	output logic                              gt,
	output logic                              eq
);
	import sls_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic [IDX_W-1:0]         tag_q;
	logic                     gt_q;
	logic                     eq_q;
	logic [CNT_W-1:0]         idx_c;
	logic [CNT_W-1:0]         nxt_c;
	logic                     in_range;
	logic                     at_end;
	logic                     pair_lo;

	// Position of this cell against the fill count
	assign idx_c    = CNT_W'(idx);
	assign nxt_c    = idx_c + CNT_W'(1);
	assign in_range = idx_c < count;
	assign at_end   = idx_c == count;
	assign pair_lo  = idx[0] == ctl.parity;

	// Compare flags and order tag are loaded when a word is taken
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			gt_q  <= data_q > value;
			eq_q  <= data_q == value;
			tag_q <= idx;
		end else if (ctl.act == ACT_SWAP) begin
			if (pair_lo && (nxt_c < count) && (tag_q < right_tag)) begin
				tag_q <= right_tag;
			end else if (!pair_lo && (idx != '0) && in_range && (left_tag < tag_q)) begin
				tag_q <= left_tag;
			end
		end
	end

	// Entry update: shift toward a neighbor, take the new value or the picked entry, or hold
	always_ff @(posedge clk) begin
		case (ctl.act)
			ACT_INSERT: begin
				if (past_gt) begin
					data_q <= left_data;
				end else if ((gt_q && in_range) || at_end) begin
					data_q <= value;
				end
			end
			ACT_DELETE: begin
				if (idx >= pos_m1) begin
					data_q <= right_data;
				end
			end
			ACT_ROTATE: begin
				if (idx == '0) begin
					data_q <= pick;
				end else if (in_range) begin
					data_q <= left_data;
				end
			end
			ACT_SWAP: begin
				if (pair_lo && (nxt_c < count) && (tag_q < right_tag)) begin
					data_q <= right_data;
				end else if (!pair_lo && (idx != '0) && in_range && (left_tag < tag_q)) begin
					data_q <= left_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;
	assign tag  = tag_q;
	assign gt   = gt_q;
	assign eq   = eq_q;

endmodule
